// ===== rtl/apem_pkg.sv =====
`timescale 1ns / 1ps

package apem_pkg;

    // Command codes
    localparam logic [2:0] CMD_UP          = 3'd1;
    localparam logic [2:0] CMD_CANCEL      = 3'd2;
    localparam logic [2:0] CMD_HOVER_LEAVE = 3'd3;
    localparam logic [2:0] CMD_BUTTON_ONLY = 3'd4;
    localparam logic [2:0] CMD_RELEASE_ALL = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_MOVE        = 3'd0;
    localparam logic [2:0] KIND_LEFT_DOWN   = 3'd1;
    localparam logic [2:0] KIND_LEFT_UP     = 3'd2;
    localparam logic [2:0] KIND_RIGHT_DOWN  = 3'd3;
    localparam logic [2:0] KIND_RIGHT_UP    = 3'd4;
    localparam logic [2:0] KIND_MIDDLE_DOWN = 3'd5;
    localparam logic [2:0] KIND_MIDDLE_UP   = 3'd6;
    localparam logic [2:0] KIND_REJECT      = 3'd7;

    // Register indexes
    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SURFACE_LEFT   = 3'd2;
    localparam logic [2:0] REG_SURFACE_TOP    = 3'd3;
    localparam logic [2:0] REG_DESK_LEFT      = 3'd4;
    localparam logic [2:0] REG_DESK_TOP       = 3'd5;
    localparam logic [2:0] REG_DESK_WIDTH     = 3'd6;
    localparam logic [2:0] REG_DESK_HEIGHT    = 3'd7;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  button_set;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] abs_x;
        logic [15:0] abs_y;
        logic        last_of_run;
    } res_word_t;

    typedef struct packed {
        logic        [15:0] surface_width;
        logic        [15:0] surface_height;
        logic signed [15:0] surface_left;
        logic signed [15:0] surface_top;
        logic signed [15:0] desk_left;
        logic signed [15:0] desk_top;
        logic        [15:0] desk_width;
        logic        [15:0] desk_height;
    } cfg_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic        reject;
        logic        need_move;
        logic [2:0]  wanted;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
    } cmd_word_t;

endpackage

// ===== rtl/absolute_pointer_event_mapper.sv =====
`timescale 1ns / 1ps

// Absolute pointer event mapper.
// Input channel: write a request word (cmd, button_set, norm_x, norm_y) with push while
// full is low. Result channel: while empty is low the oldest result word (event_kind,
// abs_x, abs_y, last_of_run) sits on result; pop takes it. One request yields zero to
// four words; last_of_run marks the final word of each request.
// Register port: wr_en, wr_index and wr_data write one of the eight geometry registers;
// write them only while no request is in flight.
// Back end: a request carrying a move passes, per axis, through one multiply, one scale, one
// clamp and a 16-step restoring divide on a shared divider, x then y; the back end then emits
// one result word per cycle while the result queue is not full. Button-only, release and
// reject requests go straight to emitting. The back end takes no new request until it has
// sent every word of the current one; the command queue holds up to CMD_QUEUE_DEPTH waiting.
// Reset: geometry registers clear to zero, no buttons held, both queues empty.
// Stall: when result is not popped the result queue fills, the back end holds its
// word, then the command queue fills and full rises.
module absolute_pointer_event_mapper #(
    parameter int CMD_QUEUE_DEPTH = 2,
    parameter int RES_QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  apem_pkg::in_word_t  request,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output apem_pkg::res_word_t result,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [15:0]         wr_data
);

    import apem_pkg::*;

    localparam int CMD_W = $bits(cmd_word_t);
    localparam int RES_W = $bits(res_word_t);

    cfg_t       cfg_reg, cfg_next;
    logic       q_push, q_full, cmd_empty, cmd_pop;
    cmd_word_t  q_word, cmd_word;
    logic       res_push, res_full;
    res_word_t  res_word;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SURFACE_WIDTH:  cfg_next.surface_width  = wr_data;
                REG_SURFACE_HEIGHT: cfg_next.surface_height = wr_data;
                REG_SURFACE_LEFT:   cfg_next.surface_left   = wr_data;
                REG_SURFACE_TOP:    cfg_next.surface_top    = wr_data;
                REG_DESK_LEFT:      cfg_next.desk_left      = wr_data;
                REG_DESK_TOP:       cfg_next.desk_top       = wr_data;
                REG_DESK_WIDTH:     cfg_next.desk_width     = wr_data;
                REG_DESK_HEIGHT:    cfg_next.desk_height    = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify requests on the way in
    apem_front u_front (
        .push    (push),
        .request (request),
        .full    (full),
        .cfg     (cfg_reg),
        .q_push  (q_push),
        .q_word  (q_word),
        .q_full  (q_full)
    );

    // Hold classified commands between front and back
    apem_queue #(
        .DEPTH (CMD_QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_word),
        .full  (q_full),
        .pop   (cmd_pop),
        .dout  (cmd_word),
        .empty (cmd_empty)
    );

    // Map coordinates and sequence the result words
    apem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_word  (cmd_word),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_full  (res_full)
    );

    // Buffer result words so the back end keeps going while the receiver stalls
    apem_queue #(
        .DEPTH (RES_QUEUE_DEPTH),
        .WIDTH (RES_W)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_word),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule

// ===== rtl/apem_queue.sv =====
`timescale 1ns / 1ps

module apem_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/apem_front.sv =====
`timescale 1ns / 1ps

module apem_front (
    input  logic                 push,
    input  apem_pkg::in_word_t   request,
    output logic                 full,
    input  apem_pkg::cfg_t       cfg,
    output logic                 q_push,
    output apem_pkg::cmd_word_t  q_word,
    input  logic                 q_full
);

    import apem_pkg::*;

    logic unusable;
    logic want_none;

    assign full      = q_full;
    assign q_push    = push;
    assign unusable  = (cfg.desk_width == '0) || (cfg.desk_height == '0);
    assign want_none = (request.cmd == CMD_UP) || (request.cmd == CMD_CANCEL)
                       || (request.cmd == CMD_HOVER_LEAVE);

    // Decide reject, move and the wanted button set up front
    always_comb
    begin
        q_word.norm_x = request.norm_x;
        q_word.norm_y = request.norm_y;
        priority if (request.cmd == CMD_RELEASE_ALL)
        begin
            q_word.reject    = 1'b0;
            q_word.need_move = 1'b0;
            q_word.wanted    = 3'b000;
        end
        else if (unusable)
        begin
            q_word.reject    = 1'b1;
            q_word.need_move = 1'b0;
            q_word.wanted    = 3'b000;
        end
        else
        begin
            q_word.reject    = 1'b0;
            q_word.need_move = !((request.cmd == CMD_HOVER_LEAVE)
                                 || (request.cmd == CMD_BUTTON_ONLY));
            q_word.wanted    = want_none ? 3'b000 : request.button_set;
        end
    end

endmodule

// ===== rtl/apem_back.sv =====
`timescale 1ns / 1ps

module apem_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  apem_pkg::cfg_t       cfg,
    input  logic                 cmd_empty,
    input  apem_pkg::cmd_word_t  cmd_word,
    output logic                 cmd_pop,
    output logic                 res_push,
    output apem_pkg::res_word_t  res_word,
    input  logic                 res_full
);

    import apem_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_PREP  = 6'b000100,
        S_CLAMP = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    // Pending result bits, lowest goes out first
    localparam int P_REJ   = 0;
    localparam int P_MOVE  = 1;
    localparam int P_LEFT  = 2;
    localparam int P_RIGHT = 3;
    localparam int P_MID   = 4;

    state_t        state_reg, state_next;
    logic [4:0]    pend_reg, pend_next;
    logic [2:0]    held_reg, held_next;
    logic [2:0]    wanted_reg, wanted_next;
    logic          axis_reg, axis_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [15:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic [31:0]   prod_reg, prod_next;
    logic signed [17:0] pix_reg, pix_next;
    logic [15:0]   rem_reg, rem_next, quo_reg, quo_next, div_reg, div_next;
    logic          zero_reg, zero_next;
    logic [15:0]   ax_reg, ax_next, ay_reg, ay_next;

    logic [15:0]   norm_sel, surf_sel, desk_sel;
    logic signed [15:0] off_sel, org_sel;
    logic [15:0]   q_est, local_pix, hi, clamped;
    logic [16:0]   r0, r1, t;
    logic          c1, c2, ge;
    logic [31:0]   num;
    logic [2:0]    chg;
    logic [4:0]    clr;
    logic          last;

    assign norm_sel = axis_reg ? ny_reg : nx_reg;
    assign surf_sel = axis_reg ? cfg.surface_height : cfg.surface_width;
    assign desk_sel = axis_reg ? cfg.desk_height : cfg.desk_width;
    assign off_sel  = axis_reg ? cfg.surface_top : cfg.surface_left;
    assign org_sel  = axis_reg ? cfg.desk_top : cfg.desk_left;

    // Divide the product by full scale: estimate, then at most two corrections
    assign q_est     = prod_reg[31:16];
    assign r0        = {1'b0, prod_reg[15:0]} + {1'b0, q_est};
    assign c1        = (r0 >= {1'b0, FULL_SCALE});
    assign r1        = c1 ? (r0 - {1'b0, FULL_SCALE}) : r0;
    assign c2        = (r1 >= {1'b0, FULL_SCALE});
    assign local_pix = q_est + {15'd0, c1} + {15'd0, c2};

    assign hi      = desk_sel - 16'd1;
    assign clamped = pix_reg[17] ? 16'd0
                   : ((pix_reg > $signed({2'b00, hi})) ? hi : pix_reg[15:0]);
    assign num     = {clamped, 16'd0} - {16'd0, clamped};

    // One restoring step
    assign t  = {rem_reg, quo_reg[15]};
    assign ge = (t >= {1'b0, div_reg});

    assign chg = cmd_word.reject ? 3'b000 : (held_reg ^ cmd_word.wanted);

    always_comb
    begin
        res_word.abs_x = 16'd0;
        res_word.abs_y = 16'd0;
        clr            = 5'd0;
        priority if (pend_reg[P_REJ])
        begin
            res_word.event_kind = KIND_REJECT;
            clr[P_REJ]          = 1'b1;
        end
        else if (pend_reg[P_MOVE])
        begin
            res_word.event_kind = KIND_MOVE;
            res_word.abs_x      = ax_reg;
            res_word.abs_y      = ay_reg;
            clr[P_MOVE]         = 1'b1;
        end
        else if (pend_reg[P_LEFT])
        begin
            res_word.event_kind = wanted_reg[0] ? KIND_LEFT_DOWN : KIND_LEFT_UP;
            clr[P_LEFT]         = 1'b1;
        end
        else if (pend_reg[P_RIGHT])
        begin
            res_word.event_kind = wanted_reg[1] ? KIND_RIGHT_DOWN : KIND_RIGHT_UP;
            clr[P_RIGHT]        = 1'b1;
        end
        else
        begin
            res_word.event_kind = wanted_reg[2] ? KIND_MIDDLE_DOWN : KIND_MIDDLE_UP;
            clr[P_MID]          = 1'b1;
        end
        last                 = ((pend_reg & ~clr) == 5'd0);
        res_word.last_of_run = last;
    end

    assign res_push = (state_reg == S_EMIT) && (pend_reg != 5'd0) && !res_full;
    assign cmd_pop  = (state_reg == S_IDLE) && !cmd_empty;

    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        held_next   = held_reg;
        wanted_next = wanted_reg;
        axis_next   = axis_reg;
        cnt_next    = cnt_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        prod_next   = prod_reg;
        pix_next    = pix_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;
        zero_next   = zero_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    pend_next   = {chg, cmd_word.need_move, cmd_word.reject};
                    held_next   = cmd_word.reject ? held_reg : cmd_word.wanted;
                    wanted_next = cmd_word.wanted;
                    nx_next     = cmd_word.norm_x;
                    ny_next     = cmd_word.norm_y;
                    axis_next   = 1'b0;
                    state_next  = cmd_word.need_move ? S_MUL : S_EMIT;
                end
            end
            S_MUL:
            begin
                prod_next  = (surf_sel > 16'd1)
                           ? (32'(norm_sel) * 32'(surf_sel - 16'd1)) : 32'd0;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                pix_next   = 18'(off_sel) - 18'(org_sel) + $signed({2'b00, local_pix});
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                rem_next   = num[31:16];
                quo_next   = num[15:0];
                div_next   = hi;
                zero_next  = (desk_sel <= 16'd1);
                cnt_next   = 4'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? 16'(t - {1'b0, div_reg}) : t[15:0];
                quo_next = {quo_reg[14:0], ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    if (!axis_reg)
                    begin
                        ax_next    = zero_reg ? 16'd0 : {quo_reg[14:0], ge};
                        axis_next  = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        ay_next    = zero_reg ? 16'd0 : {quo_reg[14:0], ge};
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (pend_reg == 5'd0)
                begin
                    state_next = S_IDLE;
                end
                else if (!res_full)
                begin
                    pend_next = pend_reg & ~clr;
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 5'd0;
            held_reg  <= 3'b000;
            axis_reg  <= 1'b0;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            held_reg  <= held_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wanted_reg <= wanted_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        prod_reg   <= prod_next;
        pix_reg    <= pix_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        zero_reg   <= zero_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
    end

    a_rej_alone: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg[P_REJ] |-> (pend_reg[4:1] == 4'd0))
        else $error("reject pending together with other results");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != S_IDLE))
        else $error("command taken but back end stayed idle");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_word.last_of_run) |=> (state_reg == S_IDLE))
        else $error("last word sent but back end did not return to idle");

    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_word.event_kind != KIND_MOVE))
        |-> ((res_word.abs_x == 16'd0) && (res_word.abs_y == 16'd0)))
        else $error("non-move word carries coordinates");

    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(held_reg))
        else $error("held buttons changed outside command load");

endmodule

// ===== bench/tb_absolute_pointer_event_mapper.sv =====
`timescale 1ns / 1ps

module tb_absolute_pointer_event_mapper;
    import apem_pkg::*;

    // Command zero and the two unused codes all mean down/move/hover
    localparam logic [2:0] CMD_POINT       = 3'd0;
    localparam logic [2:0] CMD_SPARE_SIX   = 3'd6;
    localparam logic [2:0] CMD_SPARE_SEVEN = 3'd7;

    localparam logic [2:0] NO_BUTTONS  = 3'b000;
    localparam logic [2:0] BTN_LEFT    = 3'b001;
    localparam logic [2:0] BTN_RIGHT   = 3'b010;
    localparam logic [2:0] BTN_MIDDLE  = 3'b100;
    localparam logic [2:0] ALL_BUTTONS = 3'b111;

    // Idle wait after the last owed word so zero-word requests finish too
    localparam int unsigned SETTLE_CYCLES = 64;
    // Cycles with no handshake on either side before the run is declared hung
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 50;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    in_word_t    request  = '0;
    logic        full;
    logic        empty;
    logic        pop      = 1'b0;
    res_word_t   result;
    logic        wr_en    = 1'b0;
    logic [2:0]  wr_index = REG_SURFACE_WIDTH;
    logic [15:0] wr_data  = '0;

    // Predictor state: register copy, held buttons, words still owed by the block
    cfg_t        geometry_cfg = '0;
    logic [2:0]  held_mask    = NO_BUTTONS;
    res_word_t   pending_events[$];

    int unsigned errors       = 0;
    int unsigned quiet_cycles = 0;

    // Receiver stall pattern
    int unsigned rx_stall_left = 0;
    int unsigned rx_mode_left  = 0;
    bit          rx_choppy     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    absolute_pointer_event_mapper i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One axis: normalized position -> surface pixel -> desktop pixel (clamped)
    // -> 0..65535 across the desktop.
    function automatic logic [15:0] scale_axis(logic [15:0] norm, logic [15:0] surf,
                                               logic signed [15:0] surf_off,
                                               logic signed [15:0] desk_org,
                                               logic [15:0] desk_size);
        longint surf_pixel;
        longint pix;
        longint hi;
        surf_pixel = 0;
        // A surface of one pixel or none pins the coordinate to pixel zero
        if (surf > 16'd1)
            surf_pixel = (longint'(norm) * (longint'(surf) - 1)) / longint'(FULL_SCALE);
        pix = longint'(surf_off) - longint'(desk_org) + surf_pixel;
        hi  = longint'(desk_size) - 1;
        if (hi < 0)
            hi = 0;
        if (pix < 0)
            pix = 0;
        if (pix > hi)
            pix = hi;
        // A one-pixel desktop has nowhere to go but zero
        if (desk_size <= 16'd1)
            return 16'd0;
        return 16'((pix * longint'(FULL_SCALE)) / (longint'(desk_size) - 1));
    endfunction

    function automatic void queue_word(logic [2:0] kind, logic [15:0] x, logic [15:0] y);
        res_word_t r;
        r.event_kind  = kind;
        r.abs_x       = x;
        r.abs_y       = y;
        r.last_of_run = 1'b0;
        pending_events.push_back(r);
    endfunction

    // Emit a down or up word per changed button, left then right then middle
    function automatic void report_buttons(logic [2:0] wanted);
        logic [2:0] changed;
        logic [2:0] kind;
        changed = held_mask ^ wanted;
        for (int b = 0; b < 3; b++)
        begin
            if (changed[b])
            begin
                case (b)
                    0:       kind = wanted[b] ? KIND_LEFT_DOWN : KIND_LEFT_UP;
                    1:       kind = wanted[b] ? KIND_RIGHT_DOWN : KIND_RIGHT_UP;
                    default: kind = wanted[b] ? KIND_MIDDLE_DOWN : KIND_MIDDLE_UP;
                endcase
                queue_word(kind, 16'd0, 16'd0);
            end
        end
        held_mask = wanted;
    endfunction

    // Work out every word one accepted request owes and append it
    function automatic void map_event(in_word_t w);
        int unsigned before_count;
        logic [2:0]  wanted;
        res_word_t   tail;
        before_count = pending_events.size();
        if (w.cmd == CMD_RELEASE_ALL)
        begin
            // Ignores position and desktop size entirely
            report_buttons(NO_BUTTONS);
        end
        else if (geometry_cfg.desk_width == 16'd0 || geometry_cfg.desk_height == 16'd0)
        begin
            // Unusable desktop: one reject word, held buttons stay as they are
            queue_word(KIND_REJECT, 16'd0, 16'd0);
        end
        else
        begin
            if (w.cmd != CMD_HOVER_LEAVE && w.cmd != CMD_BUTTON_ONLY)
                queue_word(KIND_MOVE,
                           scale_axis(w.norm_x, geometry_cfg.surface_width,
                                      geometry_cfg.surface_left, geometry_cfg.desk_left,
                                      geometry_cfg.desk_width),
                           scale_axis(w.norm_y, geometry_cfg.surface_height,
                                      geometry_cfg.surface_top, geometry_cfg.desk_top,
                                      geometry_cfg.desk_height));
            // Up, cancel and hover-leave want nothing held
            if (w.cmd == CMD_UP || w.cmd == CMD_CANCEL || w.cmd == CMD_HOVER_LEAVE)
                wanted = NO_BUTTONS;
            else
                wanted = w.button_set;
            report_buttons(wanted);
        end
        // Mark the final word of this request
        if (pending_events.size() > before_count)
        begin
            tail = pending_events.pop_back();
            tail.last_of_run = 1'b1;
            pending_events.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_word_t make_word(logic [2:0] cmd, logic [2:0] buttons,
                                           logic [15:0] x, logic [15:0] y);
        in_word_t w;
        w.cmd        = cmd;
        w.button_set = buttons;
        w.norm_x     = x;
        w.norm_y     = y;
        return w;
    endfunction

    function automatic cfg_t make_geometry(logic [15:0] sw, logic [15:0] sh,
                                           logic [15:0] sl, logic [15:0] st,
                                           logic [15:0] dl, logic [15:0] dt,
                                           logic [15:0] dw, logic [15:0] dh);
        cfg_t g;
        g.surface_width  = sw;
        g.surface_height = sh;
        g.surface_left   = sl;
        g.surface_top    = st;
        g.desk_left      = dl;
        g.desk_top       = dt;
        g.desk_width     = dw;
        g.desk_height    = dh;
        return g;
    endfunction

    // Mix of edge values and ordinary ones for a 16-bit register or coordinate
    function automatic logic [15:0] pick16();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h0000;
            1:       v = 16'h0001;
            2:       v = 16'hFFFF;
            3:       v = 16'h7FFF;
            4:       v = 16'h8000;
            5:       v = 16'h0002;
            6:       v = 16'($urandom_range(0, 64));
            7:       v = 16'($urandom_range(320, 4096));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Write one register; leaves wr_en high, the caller drops it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_SURFACE_WIDTH:  geometry_cfg.surface_width  = val;
            REG_SURFACE_HEIGHT: geometry_cfg.surface_height = val;
            REG_SURFACE_LEFT:   geometry_cfg.surface_left   = val;
            REG_SURFACE_TOP:    geometry_cfg.surface_top    = val;
            REG_DESK_LEFT:      geometry_cfg.desk_left      = val;
            REG_DESK_TOP:       geometry_cfg.desk_top       = val;
            REG_DESK_WIDTH:     geometry_cfg.desk_width     = val;
            default:            geometry_cfg.desk_height    = val;
        endcase
        @(negedge clk);
    endtask

    // Load all eight geometry registers; call only while the block is idle
    task automatic program_surface(input cfg_t g);
        write_reg(REG_SURFACE_WIDTH,  g.surface_width);
        write_reg(REG_SURFACE_HEIGHT, g.surface_height);
        write_reg(REG_SURFACE_LEFT,   g.surface_left);
        write_reg(REG_SURFACE_TOP,    g.surface_top);
        write_reg(REG_DESK_LEFT,      g.desk_left);
        write_reg(REG_DESK_TOP,       g.desk_top);
        write_reg(REG_DESK_WIDTH,     g.desk_width);
        write_reg(REG_DESK_HEIGHT,    g.desk_height);
        wr_en <= 1'b0;
    endtask

    // Present one request word and hold it until the block takes it.
    // Enter and leave just after a falling edge; push stays high on return
    // so back-to-back words never see it drop.
    task automatic send_word(input in_word_t w);
        bit taken;
        taken = 1'b0;
        push    <= 1'b1;
        request <= w;
        while (!taken)
        begin
            @(posedge clk);
            if (!full)
            begin
                taken = 1'b1;
                map_event(w);
            end
            else
                @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Drop push for the requested hold-off and scribble on the request bus meanwhile
    task automatic hold_off(input int unsigned n);
        if (n != 0)
        begin
            push    <= 1'b0;
            request <= make_word(3'($urandom_range(CMD_POINT, CMD_SPARE_SEVEN)),
                                 3'($urandom_range(NO_BUTTONS, ALL_BUTTONS)),
                                 16'($urandom), 16'($urandom));
            repeat (n) @(negedge clk);
        end
    endtask

    // Wait for every owed word, then let zero-word requests finish as well
    task automatic drain_results();
        push <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern, checker, watchdog
    // ------------------------------------------------------------------

    // Alternate calm stretches (no new stalls) with choppy ones (random stalls)
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_choppy    = ($urandom_range(0, 2) != 0);
            rx_mode_left = $urandom_range(50, 300);
        end
        else
            rx_mode_left--;
        if (rx_stall_left != 0)
        begin
            rx_stall_left--;
            pop <= 1'b0;
        end
        else if (rx_choppy && $urandom_range(0, 3) == 0)
        begin
            rx_stall_left = $urandom_range(0, 30);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    function automatic void check_field(string field_name, int unsigned expected_value,
                                        int unsigned actual_value);
        if (expected_value != actual_value)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field_name, expected_value, actual_value);
            errors++;
        end
    endfunction

    // Compare each popped word against the oldest owed one
    always @(posedge clk)
    begin : check_results
        res_word_t owed;
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual kind %0d x %0d y %0d last %0d",
                         $time, result.event_kind, result.abs_x, result.abs_y,
                         result.last_of_run);
                errors++;
            end
            else
            begin
                owed = pending_events.pop_front();
                check_field("event_kind", owed.event_kind, result.event_kind);
                check_field("abs_x", owed.abs_x, result.abs_x);
                check_field("abs_y", owed.abs_y, result.abs_y);
                check_field("last_of_run", owed.last_of_run, result.last_of_run);
            end
        end
    end

    // Count cycles with no handshake on either side; give up past the limit
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[absolute_pointer_event_mapper] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers still at reset: zero desktop, so everything but release-all rejects
    task automatic test_unusable_desktop();
        send_word(make_word(CMD_POINT, ALL_BUTTONS, 16'd0, 16'd0));
        send_word(make_word(CMD_BUTTON_ONLY, BTN_LEFT, FULL_SCALE, FULL_SCALE));
        // Nothing held: release-all owes no word
        send_word(make_word(CMD_RELEASE_ALL, ALL_BUTTONS, 16'd0, 16'd0));
        send_word(make_word(CMD_UP, NO_BUTTONS, 16'd1234, 16'd4321));
        drain_results();
    endtask

    // Ordinary two-monitor geometry; walk through every command
    task automatic test_command_set();
        program_surface(make_geometry(16'd1920, 16'd1080, 16'd100, -16'sd40,
                                      -16'sd1920, -16'sd200, 16'd3840, 16'd1440));
        send_word(make_word(CMD_POINT, BTN_LEFT, 16'd0, 16'd0));
        send_word(make_word(CMD_POINT, ALL_BUTTONS, FULL_SCALE, FULL_SCALE));
        // Button-only with nothing to change owes no word
        send_word(make_word(CMD_BUTTON_ONLY, ALL_BUTTONS, 16'd500, 16'd500));
        send_word(make_word(CMD_BUTTON_ONLY, BTN_RIGHT, 16'd500, 16'd500));
        send_word(make_word(CMD_HOVER_LEAVE, ALL_BUTTONS, 16'd7, 16'd9));
        send_word(make_word(CMD_SPARE_SIX, BTN_LEFT | BTN_MIDDLE, 16'h8000, 16'h7FFF));
        // Move plus three button changes: the longest run a request can owe
        send_word(make_word(CMD_SPARE_SEVEN, BTN_RIGHT, 16'h4000, 16'hC000));
        send_word(make_word(CMD_UP, ALL_BUTTONS, 16'd32768, 16'd1));
        send_word(make_word(CMD_POINT, ALL_BUTTONS, 16'd12345, 16'd54321));
        send_word(make_word(CMD_CANCEL, ALL_BUTTONS, 16'd1, 16'd65534));
        send_word(make_word(CMD_POINT, ALL_BUTTONS, 16'd100, 16'd200));
        send_word(make_word(CMD_RELEASE_ALL, NO_BUTTONS, FULL_SCALE, 16'd0));
        drain_results();
    endtask

    // Degenerate sizes, extreme offsets, one desktop axis unusable at a time
    task automatic test_geometry_extremes();
        // Surface too small and a one-pixel desktop: every move lands on zero
        program_surface(make_geometry(16'd0, 16'd1, 16'h7FFF, 16'h8000,
                                      16'h8000, 16'h7FFF, 16'd1, 16'd1));
        send_word(make_word(CMD_POINT, NO_BUTTONS, FULL_SCALE, FULL_SCALE));
        drain_results();

        // Full-size surface with offsets pushing past both clamp limits
        program_surface(make_geometry(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000,
                                      16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF));
        send_word(make_word(CMD_POINT, NO_BUTTONS, FULL_SCALE, 16'd0));
        send_word(make_word(CMD_POINT, ALL_BUTTONS, 16'd0, FULL_SCALE));
        drain_results();

        // Width zero: reject, and the held buttons stay held
        program_surface(make_geometry(16'd800, 16'd600, 16'd0, 16'd0,
                                      16'd0, 16'd0, 16'd0, 16'd600));
        send_word(make_word(CMD_BUTTON_ONLY, NO_BUTTONS, 16'd0, 16'd0));
        drain_results();

        // Height zero: release-all still raises everything held
        program_surface(make_geometry(16'd800, 16'd600, 16'd0, 16'd0,
                                      16'd0, 16'd0, 16'd800, 16'd0));
        send_word(make_word(CMD_POINT, BTN_LEFT, 16'd10, 16'd10));
        send_word(make_word(CMD_RELEASE_ALL, NO_BUTTONS, 16'd0, 16'd0));
        drain_results();
    endtask

    // Random geometry per phase, random requests sent in bursts
    task automatic test_random_traffic();
        cfg_t        g;
        bit          allow_unusable;
        bit          steady;
        int unsigned burst_left;
        logic [2:0]  cmd;
        logic [15:0] nx;
        logic [15:0] ny;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // Keep the desktop usable in most phases so requests reach the mapper
            allow_unusable = ($urandom_range(0, 5) == 0);
            steady         = (phase % 3 == 2);
            g = make_geometry(pick16(), pick16(), pick16(), pick16(),
                              pick16(), pick16(), pick16(), pick16());
            if (!allow_unusable && g.desk_width == 16'd0)
                g.desk_width = 16'($urandom_range(1, 65535));
            if (!allow_unusable && g.desk_height == 16'd0)
                g.desk_height = 16'($urandom_range(1, 65535));
            program_surface(g);

            burst_left = $urandom_range(1, 16);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                // Lean on plain pointer events; every code still shows up
                if ($urandom_range(0, 9) < 4)
                    cmd = CMD_POINT;
                else
                    cmd = 3'($urandom_range(CMD_POINT, CMD_SPARE_SEVEN));
                nx = ($urandom_range(0, 7) == 0) ? pick16() : 16'($urandom);
                ny = ($urandom_range(0, 7) == 0) ? pick16() : 16'($urandom);
                send_word(make_word(cmd, 3'($urandom_range(NO_BUTTONS, ALL_BUTTONS)),
                                    nx, ny));
                burst_left--;
                if (burst_left == 0)
                begin
                    if (!steady && $urandom_range(0, 3) != 0)
                        hold_off($urandom_range(1, 24));
                    burst_left = $urandom_range(1, 16);
                end
            end
            drain_results();
        end
    endtask

    initial
    begin
        // Hold reset low, then release it away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unusable_desktop();
        test_command_set();
        test_geometry_extremes();
        test_random_traffic();

        // Every owed word must have arrived by now
        if (pending_events.size() != 0)
        begin
            $display("%0t: %0d words never arrived, expected 0 actual %0d",
                     $time, pending_events.size(), pending_events.size());
            errors++;
        end

        if (errors == 0)
            $display("[absolute_pointer_event_mapper] OK");
        else
            $display("[absolute_pointer_event_mapper] ERROR");
        $finish;
    end

endmodule
